// ----- hw/rtl/pfe_pkg.sv -----
// Shared constants, command codes and transaction types of the programmable FSM engine.
package pfe_pkg;

    // Default table sizes and counter width
    localparam int unsigned MAX_STATES_DEF  = 16;
    localparam int unsigned MAX_TRANS_DEF   = 32;
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    // Field widths fixed by the stream format
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned SEL_W    = 4;
    localparam int unsigned REQ_W    = 16;
    localparam int unsigned COND_BITS = 16;
    localparam int unsigned IDX_W    = 5;
    localparam int unsigned ERR_W    = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_STATE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_TRANS = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESET     = 3'd4;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DUP     = 2'd2;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN = 2'd3;

    // One command transaction
    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [CODE_W-1:0]    state_code;
        logic [CODE_W-1:0]    next_code;
        logic                 initial_flag;
        logic [SEL_W-1:0]     cond_select;
        logic [REQ_W-1:0]     required_count;
        logic [COND_BITS-1:0] condition_bits;
    } pfe_cmd_t;

    // One result transaction
    typedef struct packed {
        logic              ok;
        logic              fired;
        logic [IDX_W-1:0]  fired_index;
        logic [IDX_W-1:0]  entry_index;
        logic [CODE_W-1:0] current_code;
        logic              has_current;
        logic [ERR_W-1:0]  error_code;
    } pfe_res_t;

endpackage

// ----- hw/rtl/pfe_core.sv -----
// Sequencer, table memories and shared compare/count unit of the FSM engine.
module pfe_core #(
    parameter int unsigned MAX_STATES      = pfe_pkg::MAX_STATES_DEF,
    parameter int unsigned MAX_TRANSITIONS = pfe_pkg::MAX_TRANS_DEF,
    parameter int unsigned COUNT_WIDTH     = pfe_pkg::COUNT_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  pfe_pkg::pfe_cmd_t in_cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output pfe_pkg::pfe_res_t res
);
    import pfe_pkg::*;

    localparam int unsigned SIW  = $clog2(MAX_STATES);
    localparam int unsigned SCW  = $clog2(MAX_STATES + 1);
    localparam int unsigned TIW  = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
    localparam int unsigned TCW  = $clog2(MAX_TRANSITIONS + 1);
    localparam int unsigned IW   = (SCW > TCW) ? SCW : TCW;
    localparam int unsigned TE_W = 2 * SIW + SEL_W + REQ_W;
    localparam int unsigned CMPW = (COUNT_WIDTH > REQ_W) ? COUNT_WIDTH : REQ_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b00000000001,
        ST_LOOK_RD = 11'b00000000010,
        ST_LOOK_EV = 11'b00000000100,
        ST_COMMIT  = 11'b00000001000,
        ST_TICK_RD = 11'b00000010000,
        ST_TICK_EV = 11'b00000100000,
        ST_FETCH   = 11'b00001000000,
        ST_CLR_RD  = 11'b00010000000,
        ST_CLR_EV  = 11'b00100000000,
        ST_SWEEP   = 11'b01000000000,
        ST_DONE    = 11'b10000000000
    } state_t;

    state_t            state_reg;
    pfe_cmd_t          cmd_reg;
    logic [IW-1:0]     idx_reg;
    logic [SCW-1:0]    state_count_reg;
    logic [TCW-1:0]    trans_count_reg;
    logic [SIW-1:0]    cur_idx_reg;
    logic [SIW-1:0]    init_idx_reg;
    logic              cur_valid_reg;
    logic              init_valid_reg;
    logic [CODE_W-1:0] cur_code_reg;
    logic [CODE_W-1:0] init_code_reg;
    logic [ERR_W-1:0]  sticky_err_reg;
    logic              found_s_reg;
    logic              found_d_reg;
    logic [SIW-1:0]    s_idx_reg;
    logic [SIW-1:0]    d_idx_reg;
    logic              res_ok_reg;
    logic              res_fired_reg;
    logic [IW-1:0]     res_fidx_reg;
    logic [IW-1:0]     res_eidx_reg;
    logic [ERR_W-1:0]  res_err_reg;

    // Table memories with registered read data
    logic [CODE_W-1:0]      state_mem [MAX_STATES];
    logic [TE_W-1:0]        trans_mem [MAX_TRANSITIONS];
    logic [COUNT_WIDTH-1:0] ctr_mem   [MAX_TRANSITIONS];
    logic [CODE_W-1:0]      st_rd_reg;
    logic [TE_W-1:0]        tr_rd_reg;
    logic [COUNT_WIDTH-1:0] ctr_rd_reg;

    logic                   st_we;
    logic [SIW-1:0]         st_ra;
    logic                   tr_we;
    logic                   ctr_we;
    logic [TIW-1:0]         ctr_wa;
    logic [COUNT_WIDTH-1:0] ctr_wd;

    // Fields of the transition under evaluation
    logic [SIW-1:0]         tr_src;
    logic [SIW-1:0]         tr_dst;
    logic [SEL_W-1:0]       tr_sel;
    logic [REQ_W-1:0]       tr_need;
    logic                   tr_match;
    logic                   tr_cond;
    logic [COUNT_WIDTH-1:0] ctr_inc;
    logic                   tr_fire;
    logic                   idx_at_states;
    logic                   idx_at_trans;
    logic [31:0]            fidx_ext;
    logic [31:0]            eidx_ext;

    assign tr_need  = tr_rd_reg[REQ_W-1:0];
    assign tr_sel   = tr_rd_reg[REQ_W +: SEL_W];
    assign tr_dst   = tr_rd_reg[REQ_W + SEL_W +: SIW];
    assign tr_src   = tr_rd_reg[REQ_W + SEL_W + SIW +: SIW];

    // Shared compare and saturating count unit
    assign tr_match = (tr_src == cur_idx_reg);
    assign tr_cond  = cmd_reg.condition_bits[tr_sel];
    assign ctr_inc  = (ctr_rd_reg == CNT_MAX) ? ctr_rd_reg : ctr_rd_reg + COUNT_WIDTH'(1);
    assign tr_fire  = tr_match && tr_cond && (CMPW'(ctr_inc) >= CMPW'(tr_need));

    assign idx_at_states = (idx_reg == IW'(state_count_reg));
    assign idx_at_trans  = (idx_reg == IW'(trans_count_reg));

    // Memory port control
    always_comb begin
        st_we  = (state_reg == ST_COMMIT) && (cmd_reg.cmd == CMD_ADD_STATE) && !found_s_reg;
        tr_we  = (state_reg == ST_COMMIT) && (cmd_reg.cmd == CMD_ADD_TRANS)
                 && found_s_reg && found_d_reg;
        st_ra  = (state_reg == ST_TICK_EV) ? tr_dst : idx_reg[SIW-1:0];
        ctr_we = 1'b0;
        ctr_wa = idx_reg[TIW-1:0];
        ctr_wd = '0;
        case (state_reg)
            ST_COMMIT: begin
                ctr_we = tr_we;
                ctr_wa = trans_count_reg[TIW-1:0];
            end
            ST_TICK_EV: begin
                ctr_we = tr_match;
                ctr_wd = tr_cond ? ctr_inc : '0;
            end
            ST_CLR_EV: begin
                ctr_we = tr_match;
            end
            ST_SWEEP: begin
                ctr_we = !idx_at_trans;
            end
            default: begin
                ctr_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            state_mem[state_count_reg[SIW-1:0]] <= cmd_reg.state_code;
        end
        st_rd_reg <= state_mem[st_ra];
    end

    always_ff @(posedge aclk) begin
        if (tr_we) begin
            trans_mem[trans_count_reg[TIW-1:0]] <=
                {s_idx_reg, d_idx_reg, cmd_reg.cond_select, cmd_reg.required_count};
        end
        tr_rd_reg <= trans_mem[idx_reg[TIW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (ctr_we) begin
            ctr_mem[ctr_wa] <= ctr_wd;
        end
        ctr_rd_reg <= ctr_mem[idx_reg[TIW-1:0]];
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            state_count_reg <= '0;
            trans_count_reg <= '0;
            cur_idx_reg     <= '0;
            init_idx_reg    <= '0;
            cur_valid_reg   <= 1'b0;
            init_valid_reg  <= 1'b0;
            sticky_err_reg  <= ERR_NONE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        cmd_reg       <= in_cmd;
                        res_ok_reg    <= 1'b1;
                        res_fired_reg <= 1'b0;
                        res_fidx_reg  <= '0;
                        res_eidx_reg  <= '0;
                        res_err_reg   <= ERR_NONE;
                        idx_reg       <= '0;
                        found_s_reg   <= 1'b0;
                        found_d_reg   <= 1'b0;
                        if (in_cmd.cmd == CMD_CLEAR) begin
                            state_count_reg <= '0;
                            trans_count_reg <= '0;
                            cur_idx_reg     <= '0;
                            init_idx_reg    <= '0;
                            cur_valid_reg   <= 1'b0;
                            init_valid_reg  <= 1'b0;
                            sticky_err_reg  <= ERR_NONE;
                            state_reg       <= ST_DONE;
                        end else if (in_cmd.cmd > CMD_RESET) begin
                            res_ok_reg <= 1'b0;
                            state_reg  <= ST_DONE;
                        end else if (sticky_err_reg != ERR_NONE) begin
                            res_ok_reg  <= 1'b0;
                            res_err_reg <= sticky_err_reg;
                            state_reg   <= ST_DONE;
                        end else if (in_cmd.cmd == CMD_ADD_STATE) begin
                            if (state_count_reg == SCW'(MAX_STATES)) begin
                                res_ok_reg     <= 1'b0;
                                res_err_reg    <= ERR_FULL;
                                sticky_err_reg <= ERR_FULL;
                                state_reg      <= ST_DONE;
                            end else begin
                                state_reg <= ST_LOOK_RD;
                            end
                        end else if (in_cmd.cmd == CMD_ADD_TRANS) begin
                            if (trans_count_reg == TCW'(MAX_TRANSITIONS)) begin
                                res_ok_reg     <= 1'b0;
                                res_err_reg    <= ERR_FULL;
                                sticky_err_reg <= ERR_FULL;
                                state_reg      <= ST_DONE;
                            end else begin
                                state_reg <= ST_LOOK_RD;
                            end
                        end else if (in_cmd.cmd == CMD_TICK) begin
                            state_reg <= cur_valid_reg ? ST_TICK_RD : ST_DONE;
                        end else begin
                            // Return to the initial state and clear the counter of every filled transition
                            cur_idx_reg   <= init_idx_reg;
                            cur_valid_reg <= init_valid_reg;
                            cur_code_reg  <= init_code_reg;
                            state_reg     <= ST_SWEEP;
                        end
                    end
                end
                ST_LOOK_RD: begin
                    state_reg <= idx_at_states ? ST_COMMIT : ST_LOOK_EV;
                end
                ST_LOOK_EV: begin
                    // Match both codes against one stored code
                    if (!found_s_reg && (st_rd_reg == cmd_reg.state_code)) begin
                        found_s_reg <= 1'b1;
                        s_idx_reg   <= idx_reg[SIW-1:0];
                    end
                    if (!found_d_reg && (st_rd_reg == cmd_reg.next_code)) begin
                        found_d_reg <= 1'b1;
                        d_idx_reg   <= idx_reg[SIW-1:0];
                    end
                    idx_reg   <= idx_reg + IW'(1);
                    state_reg <= ST_LOOK_RD;
                end
                ST_COMMIT: begin
                    if (cmd_reg.cmd == CMD_ADD_STATE) begin
                        if (found_s_reg) begin
                            res_ok_reg     <= 1'b0;
                            res_err_reg    <= ERR_DUP;
                            sticky_err_reg <= ERR_DUP;
                        end else begin
                            res_eidx_reg    <= IW'(state_count_reg);
                            state_count_reg <= state_count_reg + SCW'(1);
                            if (cmd_reg.initial_flag) begin
                                init_idx_reg   <= state_count_reg[SIW-1:0];
                                cur_idx_reg    <= state_count_reg[SIW-1:0];
                                init_valid_reg <= 1'b1;
                                cur_valid_reg  <= 1'b1;
                                init_code_reg  <= cmd_reg.state_code;
                                cur_code_reg   <= cmd_reg.state_code;
                            end
                        end
                    end else begin
                        if (!(found_s_reg && found_d_reg)) begin
                            res_ok_reg     <= 1'b0;
                            res_err_reg    <= ERR_UNKNOWN;
                            sticky_err_reg <= ERR_UNKNOWN;
                        end else begin
                            res_eidx_reg    <= IW'(trans_count_reg);
                            trans_count_reg <= trans_count_reg + TCW'(1);
                        end
                    end
                    state_reg <= ST_DONE;
                end
                ST_TICK_RD: begin
                    state_reg <= idx_at_trans ? ST_DONE : ST_TICK_EV;
                end
                ST_TICK_EV: begin
                    if (tr_fire) begin
                        cur_idx_reg   <= tr_dst;
                        res_fired_reg <= 1'b1;
                        res_fidx_reg  <= idx_reg;
                        state_reg     <= ST_FETCH;
                    end else begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= ST_TICK_RD;
                    end
                end
                ST_FETCH: begin
                    // Pick up the new state's code, then clear its outgoing counters
                    cur_code_reg <= st_rd_reg;
                    idx_reg      <= '0;
                    state_reg    <= ST_CLR_RD;
                end
                ST_CLR_RD: begin
                    state_reg <= idx_at_trans ? ST_DONE : ST_CLR_EV;
                end
                ST_CLR_EV: begin
                    idx_reg   <= idx_reg + IW'(1);
                    state_reg <= ST_CLR_RD;
                end
                ST_SWEEP: begin
                    if (idx_at_trans) begin
                        state_reg <= ST_DONE;
                    end else begin
                        idx_reg <= idx_reg + IW'(1);
                    end
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result transaction
    assign fidx_ext  = 32'(res_fidx_reg);
    assign eidx_ext  = 32'(res_eidx_reg);
    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb begin
        res.ok           = res_ok_reg;
        res.fired        = res_fired_reg;
        res.fired_index  = fidx_ext[IDX_W-1:0];
        res.entry_index  = eidx_ext[IDX_W-1:0];
        res.current_code = cur_valid_reg ? cur_code_reg : '0;
        res.has_current  = cur_valid_reg;
        res.error_code   = res_err_reg;
    end

    // Table fill never passes its depth
    a_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_count_reg <= SCW'(MAX_STATES)) && (trans_count_reg <= TCW'(MAX_TRANSITIONS)))
        else $error("table count beyond depth");

    // A current state always points into the filled part of the state table
    a_cur_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (SCW'(cur_idx_reg) < state_count_reg))
        else $error("current state outside state table");

    // Sticky error changes only through a clear command
    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ((sticky_err_reg != ERR_NONE) && !(in_valid && in_ready && (in_cmd.cmd == CMD_CLEAR)))
        |=> $stable(sticky_err_reg))
        else $error("sticky error changed without clear");

    // A fired tick is always a clean result
    a_fired_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.fired) |-> (res.ok && (res.error_code == ERR_NONE)))
        else $error("fired result carries an error");

    // A tick that reaches the transition scan holds a current state
    a_tick_cur: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TICK_EV) |-> cur_valid_reg)
        else $error("tick scan without current state");

endmodule

// ----- hw/rtl/programmable_fsm_engine_unit.sv -----
// Top level of the programmable FSM engine: stream ports and result register.
//
// Usage: each command enters as one transaction on the s_ channel (command code
// on s_tuser, operands on s_tdata) and produces exactly one result transaction
// on the m_ channel. The engine works on one command at a time; s_tready is high
// only while the sequencer is idle.
// Steps per command: clear, undefined command, blocked by sticky error, table
// full and idle tick go straight to the result; add state / add transition
// scan the state table, reading and then comparing each entry; a tick scans
// the transitions in the same way and, if one is taken, fetches the new
// state's code and clears that state's outgoing counters; reset to initial
// sweeps the filled counters, one entry a cycle. Each table memory has a
// single read port.
// Results sit in an output register; the sequencer accepts the next command
// while a result still waits, and holds its own result if m_tready stays low.
// Reset (aresetn low at a clock edge) empties both tables, drops the current
// and initial state and clears the sticky error; no clearing pass follows.
module programmable_fsm_engine_unit #(
    parameter int unsigned MAX_STATES      = pfe_pkg::MAX_STATES_DEF,
    parameter int unsigned MAX_TRANSITIONS = pfe_pkg::MAX_TRANS_DEF,
    parameter int unsigned COUNT_WIDTH     = pfe_pkg::COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // state_code[7:0], next_code[15:8], initial_flag[16], cond_select[20:17],
    // required_count[36:21], condition_bits[52:37], zero [55:53]
    input  logic [55:0] s_tdata,
    // cmd[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok[0], fired[1], fired_index[6:2], entry_index[11:7], current_code[19:12],
    // has_current[20], error_code[22:21], zero [23]
    output logic [23:0] m_tdata
);
    import pfe_pkg::*;

    pfe_cmd_t    in_cmd;
    pfe_res_t    res;
    logic        res_valid;
    logic        res_ready;
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;

    // Unpack the command transaction
    always_comb begin
        in_cmd.cmd            = s_tuser;
        in_cmd.state_code     = s_tdata[7:0];
        in_cmd.next_code      = s_tdata[15:8];
        in_cmd.initial_flag   = s_tdata[16];
        in_cmd.cond_select    = s_tdata[20:17];
        in_cmd.required_count = s_tdata[36:21];
        in_cmd.condition_bits = s_tdata[52:37];
    end

    pfe_core #(
        .MAX_STATES      (MAX_STATES),
        .MAX_TRANSITIONS (MAX_TRANSITIONS),
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: load when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= {1'b0, res.error_code, res.has_current, res.current_code,
                            res.entry_index, res.fired_index, res.fired, res.ok};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the programmable FSM engine: a directed table, then random sessions.
module testbench;
    import pfe_pkg::*;

    localparam int unsigned N_ST        = MAX_STATES_DEF;
    localparam int unsigned N_TR        = MAX_TRANS_DEF;
    localparam int unsigned SLOT_W      = $clog2(N_ST);
    localparam int unsigned RANDOM_CMDS = 1500;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES = 200;
    localparam int unsigned DRAIN_LIMIT = 20000;
    localparam logic [COUNT_WIDTH_DEF-1:0] HITS_MAX = '1;

    typedef enum int {
        SESS_PLAIN,
        SESS_STATE_OVERFLOW,
        SESS_ARC_OVERFLOW,
        SESS_NOISE
    } session_kind_e;

    typedef struct packed {
        logic [SLOT_W-1:0] src;
        logic [SLOT_W-1:0] dst;
        logic [SEL_W-1:0]  sel;
        logic [REQ_W-1:0]  need;
    } arc_t;

    typedef struct {
        pfe_cmd_t cmd;
        bit       typed;
        pfe_res_t res;
    } dir_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [55:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;

    always #4 aclk = ~aclk;

    programmable_fsm_engine_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow copy of the engine tables
    logic [CODE_W-1:0]          st_codes [N_ST];
    int unsigned                st_used;
    arc_t                       arcs [N_TR];
    logic [COUNT_WIDTH_DEF-1:0] arc_hits [N_TR];
    int unsigned                arcs_used;
    logic [SLOT_W-1:0]          cur_slot;
    logic [SLOT_W-1:0]          init_slot;
    bit                         cur_ok;
    bit                         init_ok;
    logic [ERR_W-1:0]           sticky_err;

    pfe_res_t    expected_results[$];
    int unsigned mismatch_count = 0;
    bit          row_typed = 1'b0;
    pfe_res_t    row_result = '0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          holdoff_req = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cmds_sent = 0;
    dir_row_t    dir_rows[$];
    logic [CODE_W-1:0] session_codes[$];

    function automatic void engine_clear();
        for (int i = 0; i < N_ST; i++) st_codes[i] = '0;
        for (int i = 0; i < N_TR; i++) begin
            arcs[i]     = '0;
            arc_hits[i] = '0;
        end
        st_used    = 0;
        arcs_used  = 0;
        cur_slot   = '0;
        init_slot  = '0;
        cur_ok     = 1'b0;
        init_ok    = 1'b0;
        sticky_err = ERR_NONE;
    endfunction

    function automatic int find_slot(logic [CODE_W-1:0] code);
        for (int i = 0; i < st_used; i++)
            if (st_codes[i] == code) return i;
        return -1;
    endfunction

    // Apply one command to the shadow engine and return the result it must produce
    function automatic pfe_res_t engine_next_result(pfe_cmd_t c);
        pfe_res_t         r;
        logic [ERR_W-1:0] err;
        int               s;
        int               d;
        r     = '0;
        r.ok  = 1'b1;
        err   = ERR_NONE;
        if (c.cmd == CMD_CLEAR) begin
            engine_clear();
        end else if (c.cmd > CMD_RESET) begin
            r.ok = 1'b0;
        end else if (sticky_err != ERR_NONE) begin
            err = sticky_err;
        end else begin
            case (c.cmd)
                CMD_ADD_STATE: begin
                    if (st_used >= N_ST) begin
                        err = ERR_FULL;
                    end else if (find_slot(c.state_code) >= 0) begin
                        err = ERR_DUP;
                    end else begin
                        st_codes[st_used] = c.state_code;
                        r.entry_index = IDX_W'(st_used);
                        if (c.initial_flag) begin
                            init_slot = SLOT_W'(st_used);
                            cur_slot  = SLOT_W'(st_used);
                            init_ok   = 1'b1;
                            cur_ok    = 1'b1;
                        end
                        st_used++;
                    end
                end
                CMD_ADD_TRANS: begin
                    if (arcs_used >= N_TR) begin
                        err = ERR_FULL;
                    end else begin
                        s = find_slot(c.state_code);
                        d = find_slot(c.next_code);
                        if (s < 0 || d < 0) begin
                            err = ERR_UNKNOWN;
                        end else begin
                            arcs[arcs_used].src  = SLOT_W'(s);
                            arcs[arcs_used].dst  = SLOT_W'(d);
                            arcs[arcs_used].sel  = c.cond_select;
                            arcs[arcs_used].need = c.required_count;
                            arc_hits[arcs_used]  = '0;
                            r.entry_index = IDX_W'(arcs_used);
                            arcs_used++;
                        end
                    end
                end
                CMD_TICK: begin
                    // Scan in insertion order; the first arc to reach its count wins
                    if (cur_ok) begin
                        for (int i = 0; i < arcs_used; i++) begin
                            if (arcs[i].src != cur_slot) continue;
                            if (!c.condition_bits[arcs[i].sel]) begin
                                arc_hits[i] = '0;
                                continue;
                            end
                            if (arc_hits[i] != HITS_MAX) arc_hits[i]++;
                            if (arc_hits[i] >= arcs[i].need) begin
                                cur_slot = arcs[i].dst;
                                for (int j = 0; j < arcs_used; j++)
                                    if (arcs[j].src == cur_slot) arc_hits[j] = '0;
                                r.fired       = 1'b1;
                                r.fired_index = IDX_W'(i);
                                break;
                            end
                        end
                    end
                end
                default: begin
                    // Reset to initial: drop back and clear every counter
                    cur_slot = init_slot;
                    cur_ok   = init_ok;
                    for (int i = 0; i < N_TR; i++) arc_hits[i] = '0;
                end
            endcase
        end
        if (err != ERR_NONE) begin
            r.ok = 1'b0;
            if (sticky_err == ERR_NONE) sticky_err = err;
        end
        r.error_code   = err;
        r.has_current  = cur_ok;
        r.current_code = cur_ok ? st_codes[cur_slot] : '0;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Check results and predict accepted commands at the rising edge
    always @(posedge aclk) begin : monitor
        pfe_res_t want;
        pfe_cmd_t seen_cmd;
        if (!aresetn) begin
            engine_clear();
            expected_results.delete();
        end else begin
            // Pop before push so a result never meets its own command
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: expected no result, actual %h", $time, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    check_field("ok",           want.ok,           m_tdata[0]);
                    check_field("fired",        want.fired,        m_tdata[1]);
                    check_field("fired_index",  want.fired_index,  m_tdata[6:2]);
                    check_field("entry_index",  want.entry_index,  m_tdata[11:7]);
                    check_field("current_code", want.current_code, m_tdata[19:12]);
                    check_field("has_current",  want.has_current,  m_tdata[20]);
                    check_field("error_code",   want.error_code,   m_tdata[22:21]);
                end
            end
            if (s_tvalid && s_tready) begin
                seen_cmd.cmd            = s_tuser;
                seen_cmd.state_code     = s_tdata[7:0];
                seen_cmd.next_code      = s_tdata[15:8];
                seen_cmd.initial_flag   = s_tdata[16];
                seen_cmd.cond_select    = s_tdata[20:17];
                seen_cmd.required_count = s_tdata[36:21];
                seen_cmd.condition_bits = s_tdata[52:37];
                want = engine_next_result(seen_cmd);
                if (row_typed) want = row_result;
                expected_results.push_back(want);
            end
        end
    end

    // Drive m_tready: random stalls, or a long hold-off when requested
    always @(negedge aclk) begin
        if (holdoff_req) begin
            hold_left   = HOLD_CYCLES;
            holdoff_req = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one command and hold it until the transaction completes
    task automatic send_cmd(input pfe_cmd_t c);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.cmd;
        s_tdata  <= {3'b000, c.condition_bits, c.required_count, c.cond_select,
                     c.initial_flag, c.next_code, c.state_code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cmds_sent++;
        @(negedge aclk);
    endtask

    function automatic pfe_cmd_t make_cmd(logic [CMD_W-1:0] cmd, logic [CODE_W-1:0] sc,
                                          logic [CODE_W-1:0] nc, logic init,
                                          logic [SEL_W-1:0] sel, logic [REQ_W-1:0] need,
                                          logic [COND_BITS-1:0] conds);
        pfe_cmd_t c;
        c.cmd            = cmd;
        c.state_code     = sc;
        c.next_code      = nc;
        c.initial_flag   = init;
        c.cond_select    = sel;
        c.required_count = need;
        c.condition_bits = conds;
        return c;
    endfunction

    function automatic pfe_res_t make_res(logic ok, logic fired, logic [IDX_W-1:0] fidx,
                                          logic [IDX_W-1:0] eidx, logic [CODE_W-1:0] code,
                                          logic has, logic [ERR_W-1:0] err);
        pfe_res_t r;
        r.ok           = ok;
        r.fired        = fired;
        r.fired_index  = fidx;
        r.entry_index  = eidx;
        r.current_code = code;
        r.has_current  = has;
        r.error_code   = err;
        return r;
    endfunction

    function automatic void add_row(pfe_cmd_t c, bit typed, pfe_res_t r);
        dir_row_t row;
        row.cmd   = c;
        row.typed = typed;
        row.res   = r;
        dir_rows.push_back(row);
    endfunction

    // Random operands around a given command code
    function automatic pfe_cmd_t random_cmd(logic [CMD_W-1:0] cmd);
        return make_cmd(cmd, CODE_W'($urandom_range(255)), CODE_W'($urandom_range(255)),
                        1'($urandom_range(1)), SEL_W'($urandom_range(15)),
                        REQ_W'($urandom), COND_BITS'($urandom));
    endfunction

    function automatic bit code_known(logic [CODE_W-1:0] code);
        foreach (session_codes[i])
            if (session_codes[i] == code) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [CODE_W-1:0] fresh_code();
        logic [CODE_W-1:0] code;
        do code = CODE_W'($urandom_range(255)); while (code_known(code));
        return code;
    endfunction

    // Mostly small counts so arcs fire; now and then any 16-bit value
    function automatic logic [REQ_W-1:0] pick_need();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll < 7) return REQ_W'($urandom_range(3));
        if (roll < 9) return REQ_W'($urandom_range(4, 12));
        return REQ_W'($urandom);
    endfunction

    function automatic logic [CODE_W-1:0] known_code();
        return session_codes[$urandom_range(session_codes.size() - 1)];
    endfunction

    // One session: clear, add states and arcs, run ticks with noise; noise kind: random commands
    task automatic run_session(session_kind_e kind);
        pfe_cmd_t             c;
        logic [COND_BITS-1:0] conds;
        int unsigned          n_states;
        int unsigned          n_arcs;
        int unsigned          n_ticks;
        int unsigned          roll;
        if (kind == SESS_NOISE) begin
            repeat (20) send_cmd(random_cmd(CMD_W'($urandom_range(7))));
            return;
        end
        send_cmd(random_cmd(CMD_CLEAR));
        session_codes.delete();

        // Build the state table
        if (kind == SESS_STATE_OVERFLOW) n_states = N_ST + 1;
        else if ($urandom_range(3) == 0) n_states = $urandom_range(9, N_ST);
        else n_states = $urandom_range(2, 6);
        for (int i = 0; i < n_states; i++) begin
            c = random_cmd(CMD_ADD_STATE);
            if (session_codes.size() != 0 && $urandom_range(39) == 0)
                c.state_code = known_code();
            else
                c.state_code = fresh_code();
            c.initial_flag = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(3) == 0);
            if (!code_known(c.state_code) && session_codes.size() < N_ST)
                session_codes.push_back(c.state_code);
            send_cmd(c);
        end

        // Build the transition table
        if (kind == SESS_ARC_OVERFLOW) n_arcs = N_TR + 1;
        else if ($urandom_range(4) == 0) n_arcs = $urandom_range(13, N_TR);
        else n_arcs = $urandom_range(1, 12);
        for (int i = 0; i < n_arcs; i++) begin
            c = random_cmd(CMD_ADD_TRANS);
            c.state_code     = known_code();
            c.next_code      = known_code();
            c.required_count = pick_need();
            roll = $urandom_range(99);
            if (roll == 0) c.state_code = fresh_code();
            else if (roll == 1) c.next_code = fresh_code();
            send_cmd(c);
        end

        // Run the machine
        n_ticks = (kind == SESS_PLAIN) ? $urandom_range(15, 45) : 4;
        conds   = COND_BITS'($urandom);
        repeat (n_ticks) begin
            roll = $urandom_range(99);
            if (roll < 6) begin
                c = random_cmd(CMD_RESET);
            end else if (roll < 9) begin
                c = random_cmd(CMD_W'($urandom_range(CMD_RESET + 1, 7)));
            end else if (roll < 10) begin
                c = random_cmd(CMD_ADD_STATE);
                if (!code_known(c.state_code) && session_codes.size() < N_ST)
                    session_codes.push_back(c.state_code);
            end else begin
                roll = $urandom_range(9);
                if (roll == 4) conds = '1;
                else if (roll == 5) conds = '0;
                else if (roll > 5) conds = COND_BITS'($urandom);
                c = random_cmd(CMD_TICK);
                c.condition_bits = conds;
            end
            send_cmd(c);
        end
    endtask

    // End the run if it hangs
    initial begin
        #12ms;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int unsigned   phase_base;
        int unsigned   sessions;
        int unsigned   waited;
        session_kind_e kind;

        // Directed table; typed results where they are plain to see
        add_row(make_cmd(CMD_TICK, 8'h00, 8'h00, 1'b0, 4'h0, 16'h0000, 16'hFFFF), 1'b1,
                make_res(1'b1, 1'b0, 5'd0, 5'd0, 8'h00, 1'b0, ERR_NONE));
        add_row(make_cmd(CMD_RESET, 8'h00, 8'h00, 1'b0, 4'h0, 16'h0000, 16'h0000), 1'b1,
                make_res(1'b1, 1'b0, 5'd0, 5'd0, 8'h00, 1'b0, ERR_NONE));
        add_row(make_cmd(3'd7, 8'h00, 8'h00, 1'b0, 4'h0, 16'h0000, 16'h0000), 1'b1,
                make_res(1'b0, 1'b0, 5'd0, 5'd0, 8'h00, 1'b0, ERR_NONE));
        add_row(make_cmd(CMD_ADD_STATE, 8'h00, 8'h00, 1'b1, 4'h0, 16'h0000, 16'h0000), 1'b1,
                make_res(1'b1, 1'b0, 5'd0, 5'd0, 8'h00, 1'b1, ERR_NONE));
        add_row(make_cmd(CMD_ADD_STATE, 8'hFF, 8'h00, 1'b0, 4'h0, 16'h0000, 16'h0000), 1'b1,
                make_res(1'b1, 1'b0, 5'd0, 5'd1, 8'h00, 1'b1, ERR_NONE));
        // A second initial state replaces the first
        add_row(make_cmd(CMD_ADD_STATE, 8'hA5, 8'h00, 1'b1, 4'h0, 16'h0000, 16'h0000), 1'b1,
                make_res(1'b1, 1'b0, 5'd0, 5'd2, 8'hA5, 1'b1, ERR_NONE));
        add_row(make_cmd(CMD_ADD_TRANS, 8'hA5, 8'hFF, 1'b0, 4'hF, 16'h0000, 16'h0000), 1'b1,
                make_res(1'b1, 1'b0, 5'd0, 5'd0, 8'hA5, 1'b1, ERR_NONE));
        add_row(make_cmd(CMD_ADD_TRANS, 8'hA5, 8'h00, 1'b0, 4'h0, 16'h0002, 16'h0000), 1'b1,
                make_res(1'b1, 1'b0, 5'd0, 5'd1, 8'hA5, 1'b1, ERR_NONE));
        add_row(make_cmd(CMD_ADD_TRANS, 8'hFF, 8'hA5, 1'b0, 4'h3, 16'hFFFF, 16'h0000), 1'b1,
                make_res(1'b1, 1'b0, 5'd0, 5'd2, 8'hA5, 1'b1, ERR_NONE));
        add_row(make_cmd(CMD_ADD_TRANS, 8'h00, 8'hFF, 1'b0, 4'h7, 16'h0001, 16'h0000), 1'b1,
                make_res(1'b1, 1'b0, 5'd0, 5'd3, 8'hA5, 1'b1, ERR_NONE));
        // Counting, zero count firing, reset to initial, a count of one
        add_row(make_cmd(CMD_TICK, 8'h00, 8'h00, 1'b0, 4'h0, 16'h0000, 16'h0001), 1'b0, '0);
        add_row(make_cmd(CMD_TICK, 8'h00, 8'h00, 1'b0, 4'h0, 16'h0000, 16'h8001), 1'b0, '0);
        add_row(make_cmd(CMD_TICK, 8'h00, 8'h00, 1'b0, 4'h0, 16'h0000, 16'h0008), 1'b0, '0);
        add_row(make_cmd(CMD_RESET, 8'h00, 8'h00, 1'b0, 4'h0, 16'h0000, 16'h0000), 1'b0, '0);
        add_row(make_cmd(CMD_TICK, 8'h00, 8'h00, 1'b0, 4'h0, 16'h0000, 16'h0001), 1'b0, '0);
        add_row(make_cmd(CMD_TICK, 8'h00, 8'h00, 1'b0, 4'h0, 16'h0000, 16'h0001), 1'b0, '0);
        add_row(make_cmd(CMD_TICK, 8'h00, 8'h00, 1'b0, 4'h0, 16'h0000, 16'hFFFF), 1'b0, '0);
        // Duplicate code, then the sticky error blocks a tick
        add_row(make_cmd(CMD_ADD_STATE, 8'hFF, 8'h00, 1'b0, 4'h0, 16'h0000, 16'h0000), 1'b1,
                make_res(1'b0, 1'b0, 5'd0, 5'd0, 8'hFF, 1'b1, ERR_DUP));
        add_row(make_cmd(CMD_TICK, 8'h00, 8'h00, 1'b0, 4'h0, 16'h0000, 16'hFFFF), 1'b0, '0);
        add_row(make_cmd(CMD_CLEAR, 8'h00, 8'h00, 1'b0, 4'h0, 16'h0000, 16'h0000), 1'b1,
                make_res(1'b1, 1'b0, 5'd0, 5'd0, 8'h00, 1'b0, ERR_NONE));
        add_row(make_cmd(CMD_ADD_TRANS, 8'h12, 8'h34, 1'b0, 4'h0, 16'h0000, 16'h0000), 1'b1,
                make_res(1'b0, 1'b0, 5'd0, 5'd0, 8'h00, 1'b0, ERR_UNKNOWN));
        // An undefined command reports no error even while one is sticky
        add_row(make_cmd(3'd6, 8'h00, 8'h00, 1'b0, 4'h0, 16'h0000, 16'h0000), 1'b1,
                make_res(1'b0, 1'b0, 5'd0, 5'd0, 8'h00, 1'b0, ERR_NONE));
        add_row(make_cmd(CMD_CLEAR, 8'h00, 8'h00, 1'b0, 4'h0, 16'h0000, 16'h0000), 1'b1,
                make_res(1'b1, 1'b0, 5'd0, 5'd0, 8'h00, 1'b0, ERR_NONE));
        add_row(make_cmd(3'd5, 8'hFF, 8'hFF, 1'b1, 4'hF, 16'hFFFF, 16'hFFFF), 1'b1,
                make_res(1'b0, 1'b0, 5'd0, 5'd0, 8'h00, 1'b0, ERR_NONE));
        // States but no initial one: a tick does nothing
        add_row(make_cmd(CMD_ADD_STATE, 8'h5A, 8'h00, 1'b0, 4'h0, 16'h0000, 16'h0000), 1'b1,
                make_res(1'b1, 1'b0, 5'd0, 5'd0, 8'h00, 1'b0, ERR_NONE));
        add_row(make_cmd(CMD_TICK, 8'h00, 8'h00, 1'b0, 4'h0, 16'h0000, 16'hFFFF), 1'b1,
                make_res(1'b1, 1'b0, 5'd0, 5'd0, 8'h00, 1'b0, ERR_NONE));

        // Hold reset, then release on a falling edge
        send_idle_pct = 33;
        recv_idle_pct = 78;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            row_typed  = dir_rows[i].typed;
            row_result = dir_rows[i].res;
            send_cmd(dir_rows[i].cmd);
        end
        row_typed = 1'b0;

        // Random sessions under three idling patterns
        sessions = 0;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 33;
                    recv_idle_pct = 78;
                end
                1: begin
                    send_idle_pct = 78;
                    recv_idle_pct = 33;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase != 1) holdoff_req = 1'b1;
            phase_base = cmds_sent;
            while (cmds_sent - phase_base < RANDOM_CMDS / 3) begin
                case (sessions % 8)
                    3:       kind = SESS_STATE_OVERFLOW;
                    5:       kind = SESS_ARC_OVERFLOW;
                    7:       kind = SESS_NOISE;
                    default: kind = SESS_PLAIN;
                endcase
                run_session(kind);
                sessions++;
            end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then watch for strays
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            mismatch_count += expected_results.size();
            $display("%0t ns: expected %0d more results, actual 0",
                     $time, expected_results.size());
        end
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/pfe_pkg.sv
hw/rtl/pfe_core.sv
hw/rtl/programmable_fsm_engine_unit.sv
dv/testbench.sv
